FILE: hw/rtl/timed_task_alarm_scheduler_core_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef TIMED_TASK_ALARM_SCHEDULER_CORE_DEFINES_SVH
`define TIMED_TASK_ALARM_SCHEDULER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checks a property on the rising clock edge, ignored during reset.
`define TTAS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scheduler assertion failed");
// Checks that a condition never holds on a rising clock edge.
`define TTAS_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("scheduler forbidden condition seen");
`else
`define TTAS_ASSERT(lbl, prop)
`define TTAS_NEVER(lbl, cond)
`endif

`endif

FILE: hw/rtl/ttas_pkg.sv
// Shared widths and the inter-cell bus type of the task alarm scheduler.
package ttas_pkg;

    localparam int TIME_W        = 32;
    localparam int IDX_W         = 2;
    localparam int SLACK_W       = 8;
    localparam int MASK_W        = 4;
    localparam int TASKS_DEFAULT = 4;
    localparam logic [SLACK_W-1:0] SLACK_RESET = 8'd1;

    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_ALARM    = 1'b1;

    // Item and running alarm state as they travel from cell to cell.
    typedef struct packed {
        logic               valid;
        logic               cmd;
        logic [IDX_W-1:0]   task_index;
        logic [TIME_W-1:0]  deadline;
        logic [TIME_W-1:0]  now;
        logic [SLACK_W-1:0] slack;
        logic [TIME_W-1:0]  alarm;
        logic               armed;
        logic               due_flag;
    } ttas_bus_t;

endpackage

FILE: hw/rtl/ttas_cell.sv
// One task entry of the scheduler chain: holds a deadline and a ready flag.
module ttas_cell #(
    parameter int IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ttas_pkg::ttas_bus_t bus_in,
    output ttas_pkg::ttas_bus_t bus_out,
    output logic                ready
);
    import ttas_pkg::*;

    // Only the first 1 << IDX_W entries can be addressed by a task index.
    localparam bit               REACHABLE = (IDX < (1 << IDX_W));
    localparam logic [IDX_W-1:0] MY_IDX    = IDX_W'(IDX);

    logic [TIME_W-1:0] deadline_reg, deadline_next;
    logic              ready_reg, ready_next;
    ttas_bus_t         bus_reg, bus_next;

    logic [TIME_W-1:0] slack_w;
    logic [TIME_W-1:0] new_age, own_age;
    logic [TIME_W-1:0] new_ahead, own_ahead, alarm_ahead;
    logic              new_due, own_due, new_earlier, own_earlier, match;

    // Wrap-around distances measured from the current time.
    assign slack_w     = {{(TIME_W-SLACK_W){1'b0}}, bus_in.slack};
    assign new_age     = bus_in.now - bus_in.deadline;
    assign own_age     = bus_in.now - deadline_reg;
    assign new_ahead   = bus_in.deadline - bus_in.now;
    assign own_ahead   = deadline_reg - bus_in.now;
    assign alarm_ahead = bus_in.alarm - bus_in.now;
    assign new_due     = (new_age <= slack_w);
    assign own_due     = (own_age <= slack_w);
    assign new_earlier = (new_ahead < alarm_ahead);
    assign own_earlier = (own_ahead < alarm_ahead);
    assign match       = REACHABLE && (bus_in.task_index == MY_IDX);

    // Update this entry and the running alarm as the item passes.
    always_comb
    begin
        deadline_next = deadline_reg;
        ready_next    = ready_reg;
        bus_next      = bus_in;
        if (bus_in.valid)
        begin
            if (bus_in.cmd == CMD_SCHEDULE)
            begin
                if (match)
                begin
                    deadline_next = bus_in.deadline;
                    if (new_due)
                    begin
                        ready_next        = 1'b1;
                        bus_next.due_flag = 1'b1;
                    end
                    else
                    begin
                        ready_next = 1'b0;
                        if (new_earlier || !bus_in.armed)
                        begin
                            bus_next.alarm = bus_in.deadline;
                            bus_next.armed = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                if (own_due)
                begin
                    ready_next = 1'b1;
                end
                else if (!ready_reg && own_earlier)
                begin
                    bus_next.alarm = deadline_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadline_reg <= '0;
            ready_reg    <= 1'b1;
            bus_reg      <= '0;
        end
        else
        begin
            deadline_reg <= deadline_next;
            ready_reg    <= ready_next;
            bus_reg      <= bus_next;
        end
    end

    assign bus_out = bus_reg;
    assign ready   = ready_reg;

endmodule

FILE: hw/rtl/timed_task_alarm_scheduler_core.sv
// Top level of the task alarm scheduler: item entry, cell chain and write-back.
//
// An item is taken at a rising edge where start is high and busy is low; cmd
// selects a schedule request (task_index, deadline, now) or an alarm-fired
// event (now only). The item walks down a row of TASKS cells, one cell per
// clock, each cell holding one task deadline and ready flag and passing the
// running alarm candidate on to its neighbor. After the last cell the alarm
// value and armed flag are written back and the result is shown for one cycle
// with done high: ready_mask, alarm_value, alarm_on and became_due.
// Done and the write-back registers capture the last cell's output. Busy drops
// as done rises, so a new item is taken only after the previous one has left the
// cell chain. The due_slack register is written through cfg_we / cfg_wdata; the
// user must write it only while idle, as the block itself does not enforce this.
// Reset clears all deadlines to zero, marks every task ready, leaves the alarm
// at zero and unarmed, and sets due_slack to one. The receiver cannot stall:
// each result must be taken in the cycle done is high.
`include "timed_task_alarm_scheduler_core_defines.svh"

module timed_task_alarm_scheduler_core #(
    parameter int TASKS = ttas_pkg::TASKS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         cmd,
    input  logic [ttas_pkg::IDX_W-1:0]   task_index,
    input  logic [ttas_pkg::TIME_W-1:0]  deadline,
    input  logic [ttas_pkg::TIME_W-1:0]  now,
    input  logic                         cfg_we,
    input  logic [ttas_pkg::SLACK_W-1:0] cfg_wdata,
    output logic                         done,
    output logic [ttas_pkg::MASK_W-1:0]  ready_mask,
    output logic [ttas_pkg::TIME_W-1:0]  alarm_value,
    output logic                         alarm_on,
    output logic                         became_due
);
    import ttas_pkg::*;

    ttas_bus_t chain [TASKS+1];
    ttas_bus_t         head;
    logic [TASKS-1:0]  ready_vec;
    logic [MASK_W-1:0] mask_now;
    ttas_bus_t         tail;
    logic              accept;

    logic [SLACK_W-1:0] slack_reg, slack_next;
    logic [TIME_W-1:0]  alarm_reg, alarm_next;
    logic [TIME_W-1:0]  alarm_dec_reg, alarm_dec_next;
    logic               armed_reg, armed_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [MASK_W-1:0]  mask_reg, mask_next;
    logic               due_reg, due_next;

    assign accept   = start && !busy_reg;
    assign tail     = chain[TASKS];
    assign chain[0] = head;

    // Item entry: an alarm event starts its search one tick before the alarm.
    always_comb
    begin
        head.valid      = accept;
        head.cmd        = cmd;
        head.task_index = task_index;
        head.deadline   = deadline;
        head.now        = now;
        head.slack      = slack_reg;
        head.alarm      = (cmd == CMD_ALARM) ? alarm_dec_reg : alarm_reg;
        head.armed      = (cmd == CMD_ALARM) ? 1'b1 : armed_reg;
        head.due_flag   = 1'b0;
    end

    // Row of task cells.
    for (genvar g = 0; g < TASKS; g++)
    begin : g_cell
        ttas_cell #(
            .IDX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bus_in  (chain[g]),
            .bus_out (chain[g+1]),
            .ready   (ready_vec[g])
        );
    end

    // Ready flags of the first tasks as seen on the result.
    for (genvar m = 0; m < MASK_W; m++)
    begin : g_mask
        if (m < TASKS)
        begin : g_on
            assign mask_now[m] = ready_vec[m];
        end
        else
        begin : g_off
            assign mask_now[m] = 1'b0;
        end
    end

    // Write-back of the alarm and result capture at the end of the chain.
    always_comb
    begin
        slack_next     = slack_reg;
        alarm_next     = alarm_reg;
        alarm_dec_next = alarm_dec_reg;
        armed_next     = armed_reg;
        busy_next      = busy_reg;
        done_next      = 1'b0;
        mask_next      = mask_reg;
        due_next       = due_reg;
        if (cfg_we)
        begin
            slack_next = cfg_wdata;
        end
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (tail.valid)
        begin
            alarm_next     = tail.alarm;
            alarm_dec_next = tail.alarm - 32'd1;
            armed_next     = tail.armed;
            busy_next      = 1'b0;
            done_next      = 1'b1;
            mask_next      = mask_now;
            due_next       = tail.due_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slack_reg     <= SLACK_RESET;
            alarm_reg     <= '0;
            alarm_dec_reg <= '1;
            armed_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            mask_reg      <= '0;
            due_reg       <= 1'b0;
        end
        else
        begin
            slack_reg     <= slack_next;
            alarm_reg     <= alarm_next;
            alarm_dec_reg <= alarm_dec_next;
            armed_reg     <= armed_next;
            busy_reg      <= busy_next;
            done_reg      <= done_next;
            mask_reg      <= mask_next;
            due_reg       <= due_next;
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign ready_mask  = mask_reg;
    assign alarm_value = alarm_reg;
    assign alarm_on    = armed_reg;
    assign became_due  = due_reg;

    // The result cycle never overlaps an item still in the chain.
    `TTAS_NEVER(a_done_while_busy, done_reg && busy_reg)
    // An accepted item keeps the block busy in the next cycle.
    `TTAS_ASSERT(a_accept_busy, accept |=> busy_reg)
    // An alarm event always leaves the alarm armed when its result appears.
    `TTAS_ASSERT(a_alarm_rearms, (accept && cmd == CMD_ALARM) |-> ##(TASKS+1) (done_reg && armed_reg))
    // An alarm event never reports a newly due schedule request.
    `TTAS_ASSERT(a_alarm_no_due, (accept && cmd == CMD_ALARM) |-> ##(TASKS+1) !due_reg)

endmodule

FILE: tb/tb_timed_task_alarm_scheduler_core.sv
// Self-checking testbench for the task alarm scheduler core: directed table, then random items.
module tb_timed_task_alarm_scheduler_core;

    timeunit 1ns;
    timeprecision 1ps;

    import ttas_pkg::*;

    localparam int TASKS = TASKS_DEFAULT;
    localparam int PHASE_ITEMS = 340;

    // One result of the block, field by field.
    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [TIME_W-1:0] alarm;
        logic              armed;
        logic              due;
    } sched_out_t;

    // One row of the directed table; fixed rows carry a hand-written result.
    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] wake;
        logic [TIME_W-1:0] at;
        logic              fixed;
        sched_out_t        want;
    } sched_row_t;

    localparam sched_out_t NO_RESULT = '0;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                cmd;
    logic [IDX_W-1:0]    task_index;
    logic [TIME_W-1:0]   deadline;
    logic [TIME_W-1:0]   now;
    logic                cfg_we;
    logic [SLACK_W-1:0]  cfg_wdata;
    logic                done;
    logic [MASK_W-1:0]   ready_mask;
    logic [TIME_W-1:0]   alarm_value;
    logic                alarm_on;
    logic                became_due;

    // Shadow copy of the scheduler state.
    logic [TIME_W-1:0]   task_deadline [TASKS];
    logic                task_rdy [TASKS];
    logic [TIME_W-1:0]   alarm_q;
    logic                alarm_armed_q;
    logic [SLACK_W-1:0]  slack_q;

    sched_out_t          pending_results [$];
    sched_row_t          directed [$];
    int                  mismatches;

    timed_task_alarm_scheduler_core #(
        .TASKS(TASKS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .task_index (task_index),
        .deadline   (deadline),
        .now        (now),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .ready_mask (ready_mask),
        .alarm_value(alarm_value),
        .alarm_on   (alarm_on),
        .became_due (became_due)
    );

    // Free-running clock, 8 ns period.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // A task is due when the wrap-around distance past its deadline is within the slack.
    function automatic logic task_is_due(logic [TIME_W-1:0] at, logic [TIME_W-1:0] wake);
        logic [TIME_W-1:0] past;
        past = at - wake;
        return past <= {{(TIME_W-SLACK_W){1'b0}}, slack_q};
    endfunction

    // Applies one item to the shadow state and returns the result it should produce.
    function automatic sched_out_t scheduler_update(logic op, logic [IDX_W-1:0] idx,
                                                    logic [TIME_W-1:0] wake,
                                                    logic [TIME_W-1:0] at);
        sched_out_t        res;
        logic [TIME_W-1:0] next;
        logic [TIME_W-1:0] dist_new;
        logic [TIME_W-1:0] dist_old;
        res = NO_RESULT;
        if (op == CMD_SCHEDULE)
        begin
            task_deadline[idx] = wake;
            if (task_is_due(at, wake))
            begin
                task_rdy[idx] = 1'b1;
                res.due = 1'b1;
            end
            else
            begin
                dist_new = wake - at;
                dist_old = alarm_q - at;
                if (dist_new < dist_old || !alarm_armed_q)
                begin
                    alarm_q = wake;
                    alarm_armed_q = 1'b1;
                end
                task_rdy[idx] = 1'b0;
            end
        end
        else
        begin
            // Sweep the table: wake due tasks, pick the nearest pending deadline.
            next = alarm_q - 1;
            for (int i = 0; i < TASKS; i++)
            begin
                if (task_is_due(at, task_deadline[i]))
                    task_rdy[i] = 1'b1;
                else if (!task_rdy[i])
                begin
                    dist_new = task_deadline[i] - at;
                    dist_old = next - at;
                    if (dist_new < dist_old)
                        next = task_deadline[i];
                end
            end
            alarm_q = next;
            alarm_armed_q = 1'b1;
        end
        for (int i = 0; i < TASKS && i < MASK_W; i++)
            res.mask[i] = task_rdy[i];
        res.alarm = alarm_q;
        res.armed = alarm_armed_q;
        return res;
    endfunction

    // Presents one item after a gap of idle cycles once the block is free,
    // and waits until the block takes it.
    task automatic issue_item(input logic op, input logic [IDX_W-1:0] idx,
                              input logic [TIME_W-1:0] wake, input logic [TIME_W-1:0] at,
                              input int gap, input logic fixed, input sched_out_t want);
        sched_out_t pred;
        if (gap > 0)
        begin
            start <= 1'b0;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            repeat (gap - 1) @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= op;
        task_index <= idx;
        deadline   <= wake;
        now        <= at;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pred = scheduler_update(op, idx, wake, at);
        pending_results.push_back(fixed ? want : pred);
    endtask

    // Writes the slack register once every outstanding result has come back.
    task automatic write_slack(input logic [SLACK_W-1:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (busy || pending_results.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        slack_q = value;
    endtask

    // Result checker: every strobed result must match the oldest expectation.
    always @(posedge clk)
    begin : result_check
        sched_out_t got;
        sched_out_t want;
        if (rst_n && done)
        begin
            got = '{ready_mask, alarm_value, alarm_on, became_due};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: mask=%h alarm=%h on=%b due=%b",
                             $realtime, got.mask, got.alarm, got.armed, got.due);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch exp/got: mask %h/%h alarm %h/%h on %b/%b due %b/%b",
                                 $realtime, want.mask, got.mask, want.alarm, got.alarm,
                                 want.armed, got.armed, want.due, got.due);
                end
            end
        end
    end

    // Main stimulus: reset, directed table, then random phases at several slack settings.
    initial
    begin : stimulus
        logic [SLACK_W-1:0] phase_slack [5];
        logic [TIME_W-1:0]  tick;
        logic [TIME_W-1:0]  at;
        logic [TIME_W-1:0]  wake;
        logic               op;
        int                 gap;
        int                 burst_left;
        int                 sel;

        mismatches = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = CMD_SCHEDULE;
        task_index = '0;
        deadline   = '0;
        now        = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        for (int i = 0; i < TASKS; i++)
        begin
            task_deadline[i] = '0;
            task_rdy[i]      = 1'b1;
        end
        alarm_q       = '0;
        alarm_armed_q = 1'b0;
        slack_q       = SLACK_RESET;

        // Fixed rows first: state right after reset is known exactly.
        directed.push_back('{CMD_SCHEDULE, 2'd0, 32'h0000_0000, 32'h0000_0000, 1'b1,
                             '{4'hF, 32'h0000_0000, 1'b0, 1'b1}});
        directed.push_back('{CMD_SCHEDULE, 2'd1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
                             '{4'hF, 32'h0000_0000, 1'b0, 1'b1}});
        // Unarmed alarm is taken by the first pending deadline.
        directed.push_back('{CMD_SCHEDULE, 2'd3, 32'd100, 32'd0, 1'b1,
                             '{4'h7, 32'd100, 1'b1, 1'b0}});
        // Earlier deadlines pull the alarm in.
        directed.push_back('{CMD_SCHEDULE, 2'd2, 32'd50, 32'd0, 1'b0, NO_RESULT});
        directed.push_back('{CMD_SCHEDULE, 2'd2, 32'd2, 32'd0, 1'b0, NO_RESULT});
        // Alarm fires: wakes task 2, re-arms at task 3.
        directed.push_back('{CMD_ALARM, 2'd0, 32'd0, 32'd2, 1'b0, NO_RESULT});
        // Alarm fires with nothing pending: alarm drops back by one.
        directed.push_back('{CMD_ALARM, 2'd1, 32'd0, 32'd100, 1'b0, NO_RESULT});
        // Deadlines across the wrap point of the timer.
        directed.push_back('{CMD_SCHEDULE, 2'd0, 32'hFFFF_FFF0, 32'hFFFF_FFE0, 1'b0,
                             NO_RESULT});
        directed.push_back('{CMD_SCHEDULE, 2'd1, 32'h0000_0010, 32'hFFFF_FFE0, 1'b0,
                             NO_RESULT});
        directed.push_back('{CMD_ALARM, 2'd2, 32'h1234_5678, 32'hFFFF_FFF1, 1'b0, NO_RESULT});
        directed.push_back('{CMD_ALARM, 2'd3, 32'hFFFF_FFFF, 32'h0000_0011, 1'b0, NO_RESULT});
        directed.push_back('{CMD_SCHEDULE, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
                             NO_RESULT});
        directed.push_back('{CMD_SCHEDULE, 2'd2, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0,
                             NO_RESULT});
        // Slack boundary: one tick past is due, two ticks past is not.
        directed.push_back('{CMD_SCHEDULE, 2'd0, 32'd8, 32'd10, 1'b0, NO_RESULT});
        directed.push_back('{CMD_SCHEDULE, 2'd0, 32'd9, 32'd10, 1'b0, NO_RESULT});
        directed.push_back('{CMD_SCHEDULE, 2'd1, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0,
                             NO_RESULT});
        directed.push_back('{CMD_SCHEDULE, 2'd3, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0,
                             NO_RESULT});
        // Alarm item with ignored fields at their extremes.
        directed.push_back('{CMD_ALARM, 2'd3, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, NO_RESULT});
        directed.push_back('{CMD_ALARM, 2'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, NO_RESULT});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed[r])
            issue_item(directed[r].op, directed[r].idx, directed[r].wake, directed[r].at,
                       $urandom_range(0, 4), directed[r].fixed, directed[r].want);

        phase_slack[0] = 8'd0;
        phase_slack[1] = 8'd255;
        phase_slack[2] = 8'($urandom_range(2, 254));
        phase_slack[3] = SLACK_RESET;
        phase_slack[4] = 8'($urandom_range(0, 255));
        burst_left = 0;

        for (int p = 0; p < 5; p++)
        begin
            write_slack(phase_slack[p]);
            // Start each phase somewhere new; one phase starts just below the wrap.
            tick = (p == 1) ? 32'hFFFF_F000 : $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                op = ($urandom_range(0, 9) < 4) ? CMD_ALARM : CMD_SCHEDULE;
                tick = tick + $urandom_range(0, 24);
                at = tick;
                sel = $urandom_range(0, 15);
                if (sel == 0)
                    at = $urandom;
                else if (op == CMD_ALARM && alarm_armed_q && sel <= 8)
                begin
                    // Fire close to the programmed alarm, as the hardware would.
                    at = alarm_q - 1 + $urandom_range(0, int'(slack_q) + 2);
                    tick = at;
                end

                sel = $urandom_range(0, 9);
                if (sel == 0)
                    wake = $urandom;
                else if (sel <= 3)
                    wake = at - $urandom_range(0, int'(slack_q) + 2);
                else
                    wake = at + $urandom_range(1, 400);

                // Idle gaps, with occasional back-to-back bursts.
                if (burst_left > 0)
                begin
                    gap = 0;
                    burst_left--;
                end
                else
                begin
                    gap = $urandom_range(0, 4);
                    if ($urandom_range(0, 19) == 0)
                        burst_left = $urandom_range(10, 40);
                end

                issue_item(op, IDX_W'($urandom_range(0, 3)), wake, at, gap, 1'b0, NO_RESULT);
            end
        end

        // Drain: wait for the remaining results, then idle so that any stray result is caught.
        start <= 1'b0;
        for (int w = 0; w < 2000 && pending_results.size() != 0; w++)
            @(posedge clk);
        repeat (TASKS + 3) @(posedge clk);
        mismatches += pending_results.size();

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #3ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: timed_task_alarm_scheduler_core.f
+incdir+hw/rtl
hw/rtl/ttas_pkg.sv
hw/rtl/ttas_cell.sv
hw/rtl/timed_task_alarm_scheduler_core.sv
tb/tb_timed_task_alarm_scheduler_core.sv
